// ===== rtl/ost_pkg.sv =====
// ----------------------------------------------------------------------------
// ost_pkg - ordered set table shared definitions
// Operation and status codes, controller states and the control interface
// between controller and datapath.
// ----------------------------------------------------------------------------
package ost_pkg;

  localparam int SET_DEPTH_DEF = 16;

  localparam logic [1:0] FN_ADD    = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_FIND   = 2'd2;
  localparam logic [1:0] FN_READ   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } ost_state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ost_cmd_t;

  typedef struct packed {
    logic out_busy;
  } ost_stat_t;

endpackage

// ===== rtl/ost_ctrl.sv =====
// ----------------------------------------------------------------------------
// ost_ctrl - ordered set table controller
// Two-state sequencer: take an item and register its match vector, then
// execute the operation once the result register is free.
// ----------------------------------------------------------------------------
module ost_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output ost_pkg::ost_cmd_t   cmd,
  input  ost_pkg::ost_stat_t  stat
);

  ost_pkg::ost_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ost_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      ost_pkg::S_IDLE: begin
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = ost_pkg::S_EXEC;
        end
      end
      ost_pkg::S_EXEC: begin
        if (!stat.out_busy) begin
          cmd.execute = 1'b1;
          state_next  = ost_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ost_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ost_datapath.sv =====
// ----------------------------------------------------------------------------
// ost_datapath - ordered set table datapath
// Row of entry cells with occupancy count, parallel match, compaction shift
// and the result register.
// ----------------------------------------------------------------------------
module ost_datapath #(
  parameter int SET_DEPTH = ost_pkg::SET_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         s_tdata,   // entry_day, entry_month, read_index
  input  logic [1:0]          s_tuser,   // func
  input  ost_pkg::ost_cmd_t   cmd,
  output ost_pkg::ost_stat_t  stat,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata    // status, found, position, out_day,
                                         // out_month, occupancy
);

  localparam int PW = $clog2(SET_DEPTH);
  localparam int CW = $clog2(SET_DEPTH + 1);

  logic [8:0]           cells [SET_DEPTH];
  logic [CW-1:0]        count, count_next;
  logic [1:0]           func;
  logic [8:0]           key;
  logic [3:0]           read_index;
  logic [SET_DEPTH-1:0] match, match_next;

  logic [1:0] status;
  logic       found;
  logic [3:0] position;
  logic [4:0] out_day;
  logic [3:0] out_month;
  logic [4:0] occupancy;

  logic [8:0]    key_in;
  logic          hit;
  logic [PW-1:0] hit_pos;
  logic          do_add, do_rem, ridx_ok;
  logic [8:0]    read_cell;
  logic [1:0]    status_next;
  logic          found_next;
  logic [PW-1:0] pos_next;
  logic [4:0]    day_next;
  logic [3:0]    month_next;

  assign key_in = {s_tdata[8:5], s_tdata[4:0]};

  always_comb begin
    for (int i = 0; i < SET_DEPTH; i++) begin
      match_next[i] = (CW'(i) < count) && (cells[i] == key_in);
    end
  end

  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < SET_DEPTH; i++) begin
      if (match[i]) hit_pos = hit_pos | PW'(i);
    end
  end

  assign hit       = |match;
  assign ridx_ok   = 32'(read_index) < 32'(count);
  assign read_cell = cells[PW'(read_index)];

  always_comb begin
    status_next = ost_pkg::ST_OK;
    found_next  = hit;
    pos_next    = hit ? hit_pos : '0;
    day_next    = '0;
    month_next  = '0;
    count_next  = count;
    do_add      = 1'b0;
    do_rem      = 1'b0;
    case (func)
      ost_pkg::FN_ADD: begin
        if (hit) begin
          status_next = ost_pkg::ST_DUP;
        end else if (count == CW'(SET_DEPTH)) begin
          status_next = ost_pkg::ST_FULL;
        end else begin
          do_add     = cmd.execute;
          pos_next   = count[PW-1:0];
          count_next = count + CW'(1);
        end
      end
      ost_pkg::FN_REMOVE: begin
        if (hit) begin
          do_rem     = cmd.execute;
          count_next = count - CW'(1);
        end else begin
          status_next = ost_pkg::ST_MISS;
        end
      end
      ost_pkg::FN_FIND: begin
        if (!hit) status_next = ost_pkg::ST_MISS;
      end
      ost_pkg::FN_READ: begin
        found_next = 1'b0;
        pos_next   = '0;
        if (ridx_ok) begin
          day_next   = read_cell[4:0];
          month_next = read_cell[8:5];
        end else begin
          status_next = ost_pkg::ST_MISS;
        end
      end
      default: begin
        status_next = ost_pkg::ST_MISS;
      end
    endcase
  end

  // compact on remove, append on add
  always_ff @(posedge clk) begin
    for (int i = 0; i < SET_DEPTH - 1; i++) begin
      if (do_rem && PW'(i) >= hit_pos) cells[i] <= cells[i+1];
    end
    for (int i = 0; i < SET_DEPTH; i++) begin
      if (do_add && count[PW-1:0] == PW'(i)) cells[i] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func       <= s_tuser;
      key        <= key_in;
      read_index <= s_tdata[12:9];
      match      <= match_next;
    end
    if (cmd.execute) begin
      status    <= status_next;
      found     <= found_next;
      position  <= 4'(pos_next);
      out_day   <= day_next;
      out_month <= month_next;
      occupancy <= 5'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.execute) count <= count_next;
      if (cmd.execute) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign stat.out_busy = m_tvalid && !m_tready;
  assign m_tdata = {3'b000, occupancy, out_month, out_day, position, found, status};

endmodule

// ===== rtl/ordered_set_table_core.sv =====
// Ordered set table: each item is accepted, then executed before the next is taken;
// a result is valid the cycle after execute and stays until taken, holding execute meanwhile.
// The accept cycle registers the match of the key against every occupied cell;
// the execute cycle applies add, remove with its compaction shift, find or read.
// Reset clears the count and result valid; cell contents stay undefined, and
// cells at or beyond the count are never read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// ordered_set_table_core - ordered set table top level
// Insertion-ordered set of day/month entries with add, remove, find, read.
// ----------------------------------------------------------------------------
module ordered_set_table_core #(
  parameter int SET_DEPTH = ost_pkg::SET_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // entry_day[4:0], entry_month[8:5], read_index[12:9]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status[1:0], found[2], position[6:3],
                                 // out_day[11:7], out_month[15:12], occupancy[20:16]
);

  ost_pkg::ost_cmd_t  cmd;
  ost_pkg::ost_stat_t stat;

  ost_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  ost_datapath #(
    .SET_DEPTH (SET_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== rtl/ost_checker.sv =====
// ----------------------------------------------------------------------------
// ost_checker - ordered set table port checks
// Result consistency and output hold rules seen at the top level ports.
// ----------------------------------------------------------------------------
module ost_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ost_pkg::ST_FULL |-> !m_tdata[2] && m_tdata[6:3] == 4'd0)
    else $error("full result with match or position");

  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ost_pkg::ST_MISS |-> !m_tdata[2] && m_tdata[15:7] == 9'd0)
    else $error("miss result with match or entry data");

endmodule

bind ordered_set_table_core ost_checker u_ost_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== bench/ordered_set_table_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_set_table_core_tb - self-checking bench for the ordered set table
// Drives add, remove, find and read items over the input stream. A tracker
// keeps its own copy of the set and predicts each reply. Replies on the output
// stream are compared in order, under several patterns of sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module ordered_set_table_core_tb;

  localparam int DEPTH      = ost_pkg::SET_DEPTH_DEF;
  localparam int QUIET_MAX  = 5000;
  localparam int SHOW_FIRST = 10;

  typedef struct packed {
    logic [4:0] occupancy;
    logic [3:0] out_month;
    logic [4:0] out_day;
    logic [3:0] position;
    logic       found;
    logic [1:0] status;
  } reply_t;

  class entry_set_tracker;
    logic [8:0] cells[DEPTH];
    int         held;
    reply_t     awaited_replies[$];
    int         mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    function void note_op(logic [1:0] op, logic [4:0] day, logic [3:0] month,
                          logic [3:0] idx);
      reply_t     r;
      logic [8:0] key;
      int         hit;
      int         i;
      r   = '0;
      key = {month, day};
      if (op == ost_pkg::FN_READ) begin
        if (idx < held) begin
          r.out_day   = cells[idx][4:0];
          r.out_month = cells[idx][8:5];
        end else begin
          r.status = ost_pkg::ST_MISS;
        end
      end else begin
        hit = -1;
        for (i = 0; i < held; i++)
          if (hit < 0 && cells[i] == key) hit = i;
        if (hit >= 0) begin
          r.found    = 1'b1;
          r.position = hit[3:0];
        end
        case (op)
          ost_pkg::FN_ADD: begin
            if (hit >= 0) begin
              r.status = ost_pkg::ST_DUP;
            end else if (held >= DEPTH) begin
              r.status = ost_pkg::ST_FULL;
            end else begin
              cells[held] = key;
              r.position  = held[3:0];
              held++;
            end
          end
          ost_pkg::FN_REMOVE: begin
            if (hit >= 0) begin
              for (i = hit; i + 1 < held; i++) cells[i] = cells[i + 1];
              held--;
            end else begin
              r.status = ost_pkg::ST_MISS;
            end
          end
          default: begin
            if (hit < 0) r.status = ost_pkg::ST_MISS;
          end
        endcase
      end
      r.occupancy = held[4:0];
      awaited_replies.push_back(r);
    endfunction

    function void check_reply(logic [23:0] data);
      reply_t got;
      reply_t want;
      got = reply_t'(data[20:0]);
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_FIRST)
          $display("%0t: unexpected reply %p", $realtime, got);
        return;
      end
      want = awaited_replies.pop_front();
      if (got.status !== want.status || got.found !== want.found ||
          got.position !== want.position || got.out_day !== want.out_day ||
          got.out_month !== want.out_month || got.occupancy !== want.occupancy ||
          data[23:21] !== 3'b000) begin
        mismatches++;
        if (mismatches <= SHOW_FIRST)
          $display("%0t: reply mismatch, expected %p, actual %p (tdata %h)",
                   $realtime, want, got, data);
      end
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  entry_set_tracker book = new();
  int gap_pct   = 0;
  int stall_pct = 0;
  int quiet     = 0;

  ordered_set_table_core #(.SET_DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        book.note_op(s_tuser, s_tdata[4:0], s_tdata[8:5], s_tdata[12:9]);
      if (m_tvalid && m_tready)
        book.check_reply(m_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("[ordered_set_table_core] ERROR");
        $finish;
      end
    end
  end

  task automatic send_op(input logic [1:0] op, input logic [4:0] day,
                         input logic [3:0] month, input logic [3:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {3'b000, idx, month, day};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int gap, input int stall,
                           input int keys);
    logic [8:0] pool[$];
    logic [8:0] key;
    logic [1:0] op;
    int         pick;
    int         k;
    gap_pct   = gap;
    stall_pct = stall;
    for (k = 0; k < keys; k++) pool.push_back(9'($urandom));
    for (k = 0; k < count; k++) begin
      key  = ($urandom_range(9) == 0) ? 9'($urandom) : pool[$urandom_range(keys - 1)];
      pick = $urandom_range(99);
      op   = (pick < 40) ? ost_pkg::FN_ADD :
             (pick < 60) ? ost_pkg::FN_REMOVE :
             (pick < 80) ? ost_pkg::FN_FIND : ost_pkg::FN_READ;
      send_op(op, key[4:0], key[8:5], 4'($urandom));
    end
  endtask

  initial begin
    int i;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = ost_pkg::FN_ADD;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_op(ost_pkg::FN_READ, 5'd0, 4'd0, 4'd0);
    send_op(ost_pkg::FN_FIND, 5'd31, 4'd15, 4'd0);
    send_op(ost_pkg::FN_REMOVE, 5'd0, 4'd0, 4'd0);
    send_op(ost_pkg::FN_ADD, 5'd0, 4'd0, 4'd0);
    send_op(ost_pkg::FN_ADD, 5'd31, 4'd15, 4'd0);
    send_op(ost_pkg::FN_ADD, 5'd31, 4'd15, 4'd0);
    for (i = 1; i <= 14; i++) send_op(ost_pkg::FN_ADD, 5'(i), 4'(15 - i), 4'd0);
    send_op(ost_pkg::FN_ADD, 5'd17, 4'd13, 4'd0);
    send_op(ost_pkg::FN_READ, 5'd0, 4'd0, 4'd15);
    send_op(ost_pkg::FN_REMOVE, 5'd0, 4'd0, 4'd0);
    send_op(ost_pkg::FN_READ, 5'd0, 4'd0, 4'd15);
    send_op(ost_pkg::FN_FIND, 5'd31, 4'd15, 4'd0);
    send_op(ost_pkg::FN_READ, 5'd31, 4'd15, 4'd0);

    run_phase(270, 0, 0, 24);
    run_phase(270, 46, 0, 20);
    run_phase(270, 0, 46, 28);
    run_phase(270, 13, 13, 18);

    @(negedge clk);
    s_tvalid = 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.mismatches == 0)
      $display("[ordered_set_table_core] OK");
    else
      $display("[ordered_set_table_core] ERROR");
    $finish;
  end

endmodule
